>>> rtl/iecl_pkg.sv
// Shared types, codes and a helper function of the IEC 104 APCI link engine.
package iecl_pkg;

    localparam int unsigned SeqWidth = 15;

    // Opcodes of an input transaction.
    localparam logic [2:0] OP_RX_FRAME  = 3'd0;
    localparam logic [2:0] OP_CONNECT   = 3'd1;
    localparam logic [2:0] OP_DISCONN   = 3'd2;
    localparam logic [2:0] OP_STARTDT   = 3'd3;
    localparam logic [2:0] OP_STOPDT    = 3'd4;
    localparam logic [2:0] OP_TESTFR    = 3'd5;
    localparam logic [2:0] OP_SEND_I    = 3'd6;

    // Link state codes.
    localparam logic [1:0] LINK_DISCONNECTED = 2'd0;
    localparam logic [1:0] LINK_CONNECTED    = 2'd1;
    localparam logic [1:0] LINK_STARTED      = 2'd2;

    // Received frame kinds.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_I    = 2'd1;
    localparam logic [1:0] KIND_S    = 2'd2;
    localparam logic [1:0] KIND_U    = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_BAD_START  = 3'd2;
    localparam logic [2:0] ST_LEN_MISM   = 3'd3;
    localparam logic [2:0] ST_SHORT_I    = 3'd4;
    localparam logic [2:0] ST_NOT_READY  = 3'd5;

    // U-format function codes.
    localparam logic [7:0] U_STARTDT_ACT = 8'h07;
    localparam logic [7:0] U_STARTDT_CON = 8'h0B;
    localparam logic [7:0] U_STOPDT_ACT  = 8'h13;
    localparam logic [7:0] U_STOPDT_CON  = 8'h23;
    localparam logic [7:0] U_TESTFR_ACT  = 8'h43;
    localparam logic [7:0] U_TESTFR_CON  = 8'h83;
    localparam logic [7:0] S_FORMAT      = 8'h01;

    localparam logic [7:0] FRAME_START_RESET = 8'd104;
    localparam logic [7:0] MAX_PAYLOAD       = 8'd243;
    localparam logic [7:0] CTRL_LENGTH       = 8'd4;
    localparam logic [7:0] I_HDR_LENGTH      = 8'd10;
    localparam logic [9:0] MIN_FRAME_BYTES   = 10'd6;
    localparam logic [9:0] MIN_I_BYTES       = 10'd12;
    localparam logic [9:0] START_LEN_BYTES   = 10'd2;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] rx_start_octet;
        logic [7:0] rx_length_octet;
        logic [9:0] rx_byte_count;
        logic [7:0] rx_control_first;
        logic [7:0] tx_payload_bytes;
    } t_req;

    typedef struct packed {
        logic                tx_valid;
        logic [7:0]          tx_length_octet;
        logic [31:0]         tx_control_word;
        logic [1:0]          rx_kind;
        logic [2:0]          status;
        logic [1:0]          link_state_out;
    } t_rsp;

    typedef struct packed {
        logic [1:0]          link_state;
        logic [SeqWidth-1:0] send_seq;
        logic [SeqWidth-1:0] recv_seq;
    } t_ctx;

    // Two control octets carrying a sequence number shifted left by one.
    function automatic logic [15:0] seq_octets(input logic [SeqWidth-1:0] seq);
        seq_octets = {seq[14:7], seq[6:0], 1'b0};
    endfunction

endpackage

>>> rtl/iecl_if.sv
// Valid/ready channel interfaces for request and response transactions.
interface iecl_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] rx_start_octet;
    logic [7:0] rx_length_octet;
    logic [9:0] rx_byte_count;
    logic [7:0] rx_control_first;
    logic [7:0] tx_payload_bytes;

    modport source (
        output valid, opcode, rx_start_octet, rx_length_octet, rx_byte_count,
               rx_control_first, tx_payload_bytes,
        input  ready
    );
    modport sink (
        input  valid, opcode, rx_start_octet, rx_length_octet, rx_byte_count,
               rx_control_first, tx_payload_bytes,
        output ready
    );
endinterface

interface iecl_rsp_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_length_octet;
    logic [31:0] tx_control_word;
    logic [1:0]  rx_kind;
    logic [2:0]  status;
    logic [1:0]  link_state_out;

    modport source (
        output valid, tx_valid, tx_length_octet, tx_control_word, rx_kind, status,
               link_state_out,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_length_octet, tx_control_word, rx_kind, status,
               link_state_out,
        output ready
    );
endinterface

>>> rtl/iecl_step.sv
// Combinational step logic: frame checks, classification and header building.
module iecl_step (
    input  iecl_pkg::t_req i_req,
    input  iecl_pkg::t_ctx i_ctx,
    input  logic [7:0]     i_start_byte,
    output iecl_pkg::t_rsp o_rsp,
    output iecl_pkg::t_ctx o_ctx
);

    logic                            w_disc;
    logic                            w_started;
    logic [7:0]                      w_pay;
    logic [iecl_pkg::SeqWidth-1:0]   w_recv_inc;

    assign w_disc     = (i_ctx.link_state == iecl_pkg::LINK_DISCONNECTED);
    assign w_started  = (i_ctx.link_state == iecl_pkg::LINK_STARTED);
    assign w_pay      = (i_req.tx_payload_bytes > iecl_pkg::MAX_PAYLOAD) ?
                        iecl_pkg::MAX_PAYLOAD : i_req.tx_payload_bytes;
    assign w_recv_inc = i_ctx.recv_seq + 1'b1;

    always_comb begin
        o_ctx = i_ctx;
        o_rsp = '0;
        case (i_req.opcode)
            iecl_pkg::OP_RX_FRAME: begin
                if (w_disc) begin
                    o_rsp.status = iecl_pkg::ST_NOT_READY;
                end else if (i_req.rx_byte_count < iecl_pkg::MIN_FRAME_BYTES) begin
                    o_rsp.status = iecl_pkg::ST_SHORT;
                end else if (i_req.rx_start_octet != i_start_byte) begin
                    o_rsp.status = iecl_pkg::ST_BAD_START;
                end else if ({2'b00, i_req.rx_length_octet} !=
                             (i_req.rx_byte_count - iecl_pkg::START_LEN_BYTES)) begin
                    o_rsp.status = iecl_pkg::ST_LEN_MISM;
                end else if (!i_req.rx_control_first[0]) begin
                    if (i_req.rx_byte_count < iecl_pkg::MIN_I_BYTES) begin
                        o_rsp.status = iecl_pkg::ST_SHORT_I;
                    end else begin
                        // Acknowledge every I frame that passes the checks with an S frame.
                        o_ctx.recv_seq        = w_recv_inc;
                        o_rsp.rx_kind         = iecl_pkg::KIND_I;
                        o_rsp.tx_valid        = 1'b1;
                        o_rsp.tx_length_octet = iecl_pkg::CTRL_LENGTH;
                        o_rsp.tx_control_word = {iecl_pkg::seq_octets(w_recv_inc),
                                                 8'h00, iecl_pkg::S_FORMAT};
                    end
                end else if (!i_req.rx_control_first[1]) begin
                    o_rsp.rx_kind = iecl_pkg::KIND_S;
                end else begin
                    o_rsp.rx_kind = iecl_pkg::KIND_U;
                    if (i_req.rx_control_first == iecl_pkg::U_STARTDT_CON) begin
                        o_ctx.link_state = iecl_pkg::LINK_STARTED;
                    end else if (i_req.rx_control_first == iecl_pkg::U_STOPDT_CON) begin
                        o_ctx.link_state = iecl_pkg::LINK_CONNECTED;
                    end else if (i_req.rx_control_first == iecl_pkg::U_TESTFR_ACT) begin
                        o_rsp.tx_valid        = 1'b1;
                        o_rsp.tx_length_octet = iecl_pkg::CTRL_LENGTH;
                        o_rsp.tx_control_word = {24'h0, iecl_pkg::U_TESTFR_CON};
                    end
                end
            end
            iecl_pkg::OP_CONNECT, iecl_pkg::OP_DISCONN: begin
                // A started link is stopped before it is torn down or reopened.
                if (w_started) begin
                    o_rsp.tx_valid        = 1'b1;
                    o_rsp.tx_length_octet = iecl_pkg::CTRL_LENGTH;
                    o_rsp.tx_control_word = {24'h0, iecl_pkg::U_STOPDT_ACT};
                end
                if (i_req.opcode == iecl_pkg::OP_CONNECT) begin
                    o_ctx.link_state = iecl_pkg::LINK_CONNECTED;
                    o_ctx.send_seq   = '0;
                    o_ctx.recv_seq   = '0;
                end else begin
                    o_ctx.link_state = iecl_pkg::LINK_DISCONNECTED;
                end
            end
            iecl_pkg::OP_STARTDT, iecl_pkg::OP_STOPDT, iecl_pkg::OP_TESTFR,
            iecl_pkg::OP_SEND_I: begin
                if (w_disc) begin
                    o_rsp.status = iecl_pkg::ST_NOT_READY;
                end else begin
                    o_rsp.tx_valid        = 1'b1;
                    o_rsp.tx_length_octet = iecl_pkg::CTRL_LENGTH;
                    if (i_req.opcode == iecl_pkg::OP_STARTDT) begin
                        o_rsp.tx_control_word = {24'h0, iecl_pkg::U_STARTDT_ACT};
                    end else if (i_req.opcode == iecl_pkg::OP_STOPDT) begin
                        o_rsp.tx_control_word = {24'h0, iecl_pkg::U_STOPDT_ACT};
                        o_ctx.link_state      = iecl_pkg::LINK_CONNECTED;
                    end else if (i_req.opcode == iecl_pkg::OP_TESTFR) begin
                        o_rsp.tx_control_word = {24'h0, iecl_pkg::U_TESTFR_ACT};
                    end else begin
                        o_rsp.tx_length_octet = iecl_pkg::I_HDR_LENGTH + w_pay;
                        o_rsp.tx_control_word = {iecl_pkg::seq_octets(i_ctx.recv_seq),
                                                 iecl_pkg::seq_octets(i_ctx.send_seq)};
                        o_ctx.send_seq        = i_ctx.send_seq + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        o_rsp.link_state_out = o_ctx.link_state;
    end

endmodule

>>> rtl/iec104_apci_link_engine.sv
// Top level of the IEC 104 APCI link engine: request and result registers, link state.
//
//   Channel   Dir   Handshake      Contents
//   i_req     in    valid/ready    opcode and received header octets
//   o_rsp     out   valid/ready    emitted header, frame kind, status, link state
//   i_cfg_*   in    write enable   expected start octet
//
// A transaction is registered on acceptance and its result is registered once the result
// register is free; one transaction is accepted every cycle while results are taken.
// Link state and sequence counters update when a transaction moves into the result
// register, so the next transaction already sees them.
// When the result is not taken the request register holds and i_req.ready drops
// only once both registers are full. Synchronous active-low reset clears control
// state and sets the start octet to 104.
module iec104_apci_link_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    iecl_req_if.sink          i_req,
    iecl_rsp_if.source        o_rsp
);

    logic                 r_in_valid;
    iecl_pkg::t_req       r_req;
    logic                 r_out_valid;
    iecl_pkg::t_rsp       r_rsp;
    iecl_pkg::t_ctx       r_ctx;
    logic [7:0]           r_start_byte;

    iecl_pkg::t_rsp       n_rsp;
    iecl_pkg::t_ctx       n_ctx;
    logic                 w_adv;
    logic                 w_fire;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign w_fire      = r_in_valid && w_adv;
    assign i_req.ready = !r_in_valid || w_adv;

    iecl_step u_step (
        .i_req        (r_req),
        .i_ctx        (r_ctx),
        .i_start_byte (r_start_byte),
        .o_rsp        (n_rsp),
        .o_ctx        (n_ctx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ctx        <= '{link_state: iecl_pkg::LINK_DISCONNECTED,
                              send_seq: '0, recv_seq: '0};
            r_start_byte <= iecl_pkg::FRAME_START_RESET;
        end else begin
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_wdata;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_ctx <= n_ctx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.opcode           <= i_req.opcode;
            r_req.rx_start_octet   <= i_req.rx_start_octet;
            r_req.rx_length_octet  <= i_req.rx_length_octet;
            r_req.rx_byte_count    <= i_req.rx_byte_count;
            r_req.rx_control_first <= i_req.rx_control_first;
            r_req.tx_payload_bytes <= i_req.tx_payload_bytes;
        end
        if (w_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.tx_valid        = r_rsp.tx_valid;
    assign o_rsp.tx_length_octet = r_rsp.tx_length_octet;
    assign o_rsp.tx_control_word = r_rsp.tx_control_word;
    assign o_rsp.rx_kind         = r_rsp.rx_kind;
    assign o_rsp.status          = r_rsp.status;
    assign o_rsp.link_state_out  = r_rsp.link_state_out;

    // A stalled request must stay in its register until the result side frees up.
    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("request lost while result register was blocked");

    // Every emitted header carries at least the four control octets.
    a_tx_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.tx_valid) |->
        (r_rsp.tx_length_octet >= iecl_pkg::CTRL_LENGTH &&
         r_rsp.tx_length_octet <= 8'd253))
        else $error("emitted header length out of range");

    // A classified frame always comes with an ok status.
    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.rx_kind != iecl_pkg::KIND_NONE) |->
        (r_rsp.status == iecl_pkg::ST_OK))
        else $error("frame classified with error status");

    // The reported link state follows the state register after each transaction.
    a_state_rpt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_rsp.link_state_out == r_ctx.link_state))
        else $error("reported link state disagrees with state register");

endmodule
